// ===== sv/mpmc_pkg.sv =====
package mpmc_pkg;

  typedef enum logic [2:0] {
    CMD_PAT_LETTER = 3'd0,
    CMD_PAT_END    = 3'd1,
    CMD_BUILD      = 3'd2,
    CMD_TEXT       = 3'd3,
    CMD_RESTART    = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] letter;
  } in_item_t;

  typedef struct packed {
    logic [31:0] match_total;
    logic        overflow;
    logic        build_done;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAT_RD,
    ST_PAT_WAIT,
    ST_END_RD,
    ST_END_WAIT,
    ST_TXT_RD,
    ST_TXT_WAIT,
    ST_CH_RD,
    ST_CH_WAIT,
    ST_BR_RD,
    ST_BR_WAIT,
    ST_BQ_RD,
    ST_BQ_WAIT,
    ST_BF_WAIT,
    ST_BU_RD,
    ST_BU_WAIT,
    ST_BF2_RD,
    ST_BF2_WAIT,
    ST_RESP
  } state_t;

endpackage

// ===== sv/multi_pattern_match_counter.sv =====
// aho-corasick multi-pattern counter
// input channel (in_valid/in_ready, in_data) carries a command and a letter;
// output channel (out_valid/out_ready, out_data) returns one result for each
// command 0..4, commands 5..7 are dropped with no result.
// one item is in work at a time. a pattern letter or an end pattern passes
// through a read state and a wait state before the result state; a restart or
// a command that changes nothing goes straight to the result state; a text
// letter reads its goto edge, then checks the failure chain node by node.
// the first build sweeps the root slots, then for each trie node in queue
// order reads its fail link and visits every letter of the alphabet; each
// letter step reads the single-port child table and may write it later.
// a new item is taken from the cycle after the result transfer.
// after reset the block clears the end count and counted mark memories and
// the child table, one entry of each a cycle, and takes no item meanwhile.
// the result sits in an output register; while the receiver stalls the block
// holds it and takes no further item.
module multi_pattern_match_counter #(
  parameter int NODES    = 4096,
  parameter int ALPHABET = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mpmc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mpmc_pkg::out_item_t  out_data
);

  localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int AW    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int SLOTS = NODES * ALPHABET;
  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = AW + 1;

  // memories
  logic [NW-1:0] child_mem [SLOTS];
  logic [NW-1:0] fail_mem  [NODES];
  logic [15:0]   endc_mem  [NODES];
  logic          mark_mem  [NODES];
  logic [NW-1:0] queue_mem [NODES];

  logic          ch_we, fl_we, ec_we, mk_we, q_we;
  logic [SW-1:0] ch_addr;
  logic [NW-1:0] ch_wdata, ch_rdata;
  logic [NW-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;
  logic [NW-1:0] ec_addr;
  logic [15:0]   ec_wdata, ec_rdata;
  logic [NW-1:0] mk_addr;
  logic          mk_wdata, mk_rdata;
  logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (ch_we) child_mem[ch_addr] <= ch_wdata;
    ch_rdata <= child_mem[ch_addr];
  end
  always_ff @(posedge clk) begin
    if (fl_we) fail_mem[fl_waddr] <= fl_wdata;
    fl_rdata <= fail_mem[fl_raddr];
  end
  always_ff @(posedge clk) begin
    if (ec_we) endc_mem[ec_addr] <= ec_wdata;
    ec_rdata <= endc_mem[ec_addr];
  end
  always_ff @(posedge clk) begin
    if (mk_we) mark_mem[mk_addr] <= mk_wdata;
    mk_rdata <= mark_mem[mk_addr];
  end
  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    q_rdata <= queue_mem[q_raddr];
  end

  function automatic logic [SW-1:0] slot_of(input logic [NW-1:0] n, input logic [LW-1:0] c);
    logic [SW+NW-1:0] p;
    p = (SW+NW)'(n) * (SW+NW)'(ALPHABET) + (SW+NW)'(c);
    return p[SW-1:0];
  endfunction

  // registers
  mpmc_pkg::state_t state, state_next;
  logic [SW-1:0] clr, clr_next;
  logic [NW-1:0] node_count, node_count_next;
  logic [NW-1:0] cursor, cursor_next;
  logic [31:0]   total, total_next;
  logic          built, built_next;
  logic [2:0]    cmd, cmd_next;
  logic [LW-1:0] ltr, ltr_next;
  logic [NW-1:0] jn, jn_next;       // chain node / build node u
  logic [NW-1:0] fn, fn_next;       // fail of u
  logic [NW-1:0] cn, cn_next;       // child c
  logic [NW:0]   head, head_next, tail, tail_next;
  logic          ovf, ovf_next, bd, bd_next;
  logic          ovalid, ovalid_next;

  // an empty slot in the build sweep is recorded so the write-back knows
  logic fill_flag;
  logic ch_rdata_is_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mpmc_pkg::ST_CLEAR;
      clr        <= '0;
      node_count <= '0;
      cursor     <= '0;
      total      <= '0;
      built      <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      state      <= state_next;
      clr        <= clr_next;
      node_count <= node_count_next;
      cursor     <= cursor_next;
      total      <= total_next;
      built      <= built_next;
      ovalid     <= ovalid_next;
    end
    cmd  <= cmd_next;
    ltr  <= ltr_next;
    jn   <= jn_next;
    fn   <= fn_next;
    cn   <= cn_next;
    head <= head_next;
    tail <= tail_next;
    ovf  <= ovf_next;
    bd   <= bd_next;
  end

  assign in_ready  = (state == mpmc_pkg::ST_IDLE) && !ovalid;
  assign out_valid = ovalid;
  assign out_data  = '{match_total: total, overflow: ovf, build_done: bd};

  logic [32:0] sum;
  assign sum = {1'b0, total} + {17'd0, ec_rdata};

  always_comb begin
    state_next = state;
    clr_next = clr;
    node_count_next = node_count;
    cursor_next = cursor;
    total_next = total;
    built_next = built;
    cmd_next = cmd;
    ltr_next = ltr;
    jn_next = jn;
    fn_next = fn;
    cn_next = cn;
    head_next = head;
    tail_next = tail;
    ovf_next = ovf;
    bd_next = bd;
    ovalid_next = ovalid && !out_ready;
    ch_we = 1'b0; ch_addr = slot_of(cursor, ltr); ch_wdata = '0;
    fl_we = 1'b0; fl_waddr = '0; fl_raddr = jn; fl_wdata = '0;
    ec_we = 1'b0; ec_addr = jn; ec_wdata = '0;
    mk_we = 1'b0; mk_addr = jn; mk_wdata = 1'b0;
    q_we = 1'b0; q_waddr = tail[NW-1:0]; q_raddr = head[NW-1:0]; q_wdata = cn;
    case (state)
      mpmc_pkg::ST_CLEAR: begin
        ch_we = 1'b1; ch_addr = clr;
        ec_we = 1'b1; ec_addr = clr[NW-1:0];
        mk_we = 1'b1; mk_addr = clr[NW-1:0];
        clr_next = clr + 1'b1;
        if (clr == SW'(SLOTS - 1)) state_next = mpmc_pkg::ST_IDLE;
      end
      mpmc_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_next = in_data.command;
          ltr_next = LW'(in_data.letter);
          ovf_next = 1'b0;
          bd_next = 1'b0;
          jn_next = cursor;
          case (in_data.command)
            mpmc_pkg::CMD_PAT_LETTER:
              state_next = (!built && 32'(in_data.letter) < ALPHABET) ?
                           mpmc_pkg::ST_PAT_RD : mpmc_pkg::ST_RESP;
            mpmc_pkg::CMD_PAT_END:
              state_next = built ? mpmc_pkg::ST_RESP : mpmc_pkg::ST_END_RD;
            mpmc_pkg::CMD_BUILD: begin
              bd_next = 1'b1;
              cursor_next = '0;
              head_next = '0;
              tail_next = '0;
              ltr_next = '0;
              state_next = built ? mpmc_pkg::ST_RESP : mpmc_pkg::ST_BR_RD;
            end
            mpmc_pkg::CMD_TEXT:
              state_next = (built && 32'(in_data.letter) < ALPHABET) ?
                           mpmc_pkg::ST_TXT_RD : mpmc_pkg::ST_RESP;
            mpmc_pkg::CMD_RESTART: begin
              cursor_next = '0;
              state_next = mpmc_pkg::ST_RESP;
            end
            default: ;
          endcase
        end
      end
      mpmc_pkg::ST_PAT_RD: state_next = mpmc_pkg::ST_PAT_WAIT;
      mpmc_pkg::ST_PAT_WAIT: begin
        if (ch_rdata != '0) begin
          cursor_next = ch_rdata;
        end else if (32'(node_count) + 1 < NODES) begin
          node_count_next = node_count + 1'b1;
          ch_we = 1'b1;
          ch_wdata = node_count + 1'b1;
          cursor_next = node_count + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
        state_next = mpmc_pkg::ST_RESP;
      end
      mpmc_pkg::ST_END_RD: state_next = mpmc_pkg::ST_END_WAIT;
      mpmc_pkg::ST_END_WAIT: begin
        ec_we = (ec_rdata != 16'hFFFF);
        ec_wdata = ec_rdata + 16'd1;
        cursor_next = '0;
        state_next = mpmc_pkg::ST_RESP;
      end
      mpmc_pkg::ST_TXT_RD: state_next = mpmc_pkg::ST_TXT_WAIT;
      mpmc_pkg::ST_TXT_WAIT: begin
        cursor_next = ch_rdata;
        jn_next = ch_rdata;
        state_next = (ch_rdata == '0) ? mpmc_pkg::ST_RESP : mpmc_pkg::ST_CH_RD;
      end
      // chain: read mark, end count and fail link of jn
      mpmc_pkg::ST_CH_RD: state_next = mpmc_pkg::ST_CH_WAIT;
      mpmc_pkg::ST_CH_WAIT: begin
        if (mk_rdata) begin
          state_next = mpmc_pkg::ST_RESP;
        end else begin
          total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          mk_we = 1'b1;
          mk_wdata = 1'b1;
          jn_next = fl_rdata;
          state_next = (fl_rdata == '0) ? mpmc_pkg::ST_RESP : mpmc_pkg::ST_CH_RD;
        end
      end
      // root children: fail = 0, enqueue
      mpmc_pkg::ST_BR_RD: begin
        ch_addr = slot_of('0, ltr);
        state_next = mpmc_pkg::ST_BR_WAIT;
      end
      mpmc_pkg::ST_BR_WAIT: begin
        ch_addr = slot_of('0, ltr);
        if (ch_rdata != '0) begin
          fl_we = 1'b1; fl_waddr = ch_rdata; fl_wdata = '0;
          q_we = 1'b1; q_wdata = ch_rdata;
          tail_next = tail + 1'b1;
        end
        ltr_next = ltr + 1'b1;
        state_next = (32'(ltr) == ALPHABET - 1) ? mpmc_pkg::ST_BQ_RD : mpmc_pkg::ST_BR_RD;
      end
      mpmc_pkg::ST_BQ_RD: begin
        if (head == tail) begin
          built_next = 1'b1;
          state_next = mpmc_pkg::ST_RESP;
        end else begin
          head_next = head + 1'b1;
          state_next = mpmc_pkg::ST_BQ_WAIT;
        end
      end
      mpmc_pkg::ST_BQ_WAIT: begin
        jn_next = q_rdata;
        ltr_next = '0;
        state_next = mpmc_pkg::ST_BF_WAIT;
      end
      mpmc_pkg::ST_BF_WAIT: begin
        // fail_mem read of jn issued this cycle, result next cycle
        state_next = mpmc_pkg::ST_BU_RD;
      end
      mpmc_pkg::ST_BU_RD: begin
        if (ltr == '0) fn_next = fl_rdata;
        ch_addr = slot_of(jn, ltr);
        state_next = mpmc_pkg::ST_BU_WAIT;
      end
      mpmc_pkg::ST_BU_WAIT: begin
        cn_next = ch_rdata;
        ch_addr = slot_of(fn, ltr);
        state_next = mpmc_pkg::ST_BF2_RD;
      end
      mpmc_pkg::ST_BF2_RD: begin
        ch_addr = slot_of(fn, ltr);
        if (cn != '0) begin
          fl_we = 1'b1; fl_waddr = cn; fl_wdata = ch_rdata;
          if (tail < (NW+1)'(NODES)) begin
            q_we = 1'b1;
            tail_next = tail + 1'b1;
          end
          state_next = mpmc_pkg::ST_BF2_WAIT;
        end else begin
          fn_next = fn;
          cn_next = ch_rdata;
          state_next = mpmc_pkg::ST_BF2_WAIT;
        end
      end
      mpmc_pkg::ST_BF2_WAIT: begin
        ch_addr = slot_of(jn, ltr);
        if (cmd == mpmc_pkg::CMD_BUILD) begin
          // fill the missing goto edge with the fail target's edge
          ch_we = (ch_rdata_is_fill);
          ch_wdata = cn;
        end
        ltr_next = ltr + 1'b1;
        state_next = (32'(ltr) == ALPHABET - 1) ? mpmc_pkg::ST_BQ_RD : mpmc_pkg::ST_BU_RD;
      end
      mpmc_pkg::ST_RESP: begin
        ovalid_next = 1'b1;
        state_next = mpmc_pkg::ST_IDLE;
      end
      default: state_next = mpmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == mpmc_pkg::ST_BF2_RD) fill_flag <= (cn == '0);
  end
  assign ch_rdata_is_fill = fill_flag;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == mpmc_pkg::ST_IDLE)
    else $error("ready outside idle");
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    cursor <= node_count || built)
    else $error("cursor past allocated nodes");
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    total >= $past(total) || $past(rst))
    else $error("total decreased");
  a_nodes: assert property (@(posedge clk) disable iff (rst)
    built |=> node_count == $past(node_count))
    else $error("node added after build");
`endif

endmodule

// ===== sim/tb_multi_pattern_match_counter.sv =====
`timescale 1ns / 1ps

module tb_multi_pattern_match_counter;

  localparam int NODES = 4096;
  localparam int ALPHA = 26;
  localparam int CYCLE_LIMIT = 8000000;
  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
  localparam logic [4:0] LETTER_MAX = 5'd31;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mpmc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mpmc_pkg::out_item_t out_data;

  multi_pattern_match_counter #(.NODES(NODES), .ALPHABET(ALPHA)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // automaton mirror
  logic [11:0] trie_next [NODES*ALPHA];
  logic [11:0] fail_of [NODES];
  logic [15:0] ends_at [NODES];
  bit          seen_node [NODES];
  int          bfs_q [NODES];
  int          used_nodes = 0;
  int          walk_node = 0;
  logic [31:0] total_hits = '0;
  bit          links_ready = 1'b0;
  int          ovf_hits = 0;

  mpmc_pkg::out_item_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;
  bit rx_idle_on = 1'b1;
  bit tx_idle_on = 1'b1;
  int text_sent = 0;
  int pattern_sent = 0;

  function automatic void fill_links();
    int head, tail, u, f, c;
    head = 0;
    tail = 0;
    fail_of[0] = '0;
    for (int ch = 0; ch < ALPHA; ch++) begin
      c = trie_next[ch];
      if (c != 0 && tail < NODES) begin
        fail_of[c] = '0;
        bfs_q[tail] = c;
        tail++;
      end
    end
    while (head < tail) begin
      u = bfs_q[head];
      head++;
      f = fail_of[u];
      for (int ch = 0; ch < ALPHA; ch++) begin
        c = trie_next[u*ALPHA+ch];
        if (c != 0) begin
          fail_of[c] = trie_next[f*ALPHA+ch];
          if (tail < NODES) begin
            bfs_q[tail] = c;
            tail++;
          end
        end else begin
          trie_next[u*ALPHA+ch] = trie_next[f*ALPHA+ch];
        end
      end
    end
  endfunction

  function automatic void scan_text(int ch);
    int j, guard;
    longint sum;
    walk_node = trie_next[walk_node*ALPHA+ch];
    j = walk_node;
    guard = 0;
    while (j != 0 && !seen_node[j] && guard < NODES) begin
      sum = longint'(total_hits) + longint'(ends_at[j]);
      total_hits = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      seen_node[j] = 1'b1;
      j = fail_of[j];
      guard++;
    end
  endfunction

  function automatic void predict(input mpmc_pkg::in_item_t it, output bit has,
                                  output mpmc_pkg::out_item_t r);
    int ch, s;
    ch = it.letter;
    has = 1'b1;
    r = '0;
    case (it.command)
      mpmc_pkg::CMD_PAT_LETTER: begin
        if (!links_ready && ch < ALPHA) begin
          s = walk_node*ALPHA + ch;
          if (trie_next[s] == 0) begin
            if (used_nodes + 1 < NODES) begin
              used_nodes++;
              trie_next[s] = used_nodes[11:0];
              walk_node = used_nodes;
            end else begin
              r.overflow = 1'b1;
              ovf_hits++;
            end
          end else begin
            walk_node = trie_next[s];
          end
        end
      end
      mpmc_pkg::CMD_PAT_END: begin
        if (!links_ready) begin
          if (ends_at[walk_node] != 16'hFFFF) ends_at[walk_node]++;
          walk_node = 0;
        end
      end
      mpmc_pkg::CMD_BUILD: begin
        if (!links_ready) begin
          fill_links();
          links_ready = 1'b1;
        end
        walk_node = 0;
        r.build_done = 1'b1;
      end
      mpmc_pkg::CMD_TEXT: begin
        if (links_ready && ch < ALPHA) scan_text(ch);
      end
      mpmc_pkg::CMD_RESTART: walk_node = 0;
      default: has = 1'b0;
    endcase
    r.match_total = total_hits;
  endfunction

  task automatic send(input logic [2:0] c, input logic [4:0] l,
                      input bit typed = 1'b0, input mpmc_pkg::out_item_t typed_val = '0);
    mpmc_pkg::in_item_t it;
    bit has;
    mpmc_pkg::out_item_t r;
    int gap;
    it.command = c;
    it.letter = l;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict(it, has, r);
    if (has) expected_q.push_back(typed ? typed_val : r);
    if (c == mpmc_pkg::CMD_TEXT) text_sent++;
    if (c == mpmc_pkg::CMD_PAT_LETTER || c == mpmc_pkg::CMD_PAT_END) pattern_sent++;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender pause until the block has drained
  task automatic drain();
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    @(posedge clk);
  endtask

  function automatic logic [4:0] pick_letter();
    return ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 25));
  endfunction

  task automatic check_result(input mpmc_pkg::out_item_t got);
    mpmc_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h at cycle %0d", got, cycles);
    end else begin
      want = expected_q.pop_front();
      if (got.match_total !== want.match_total || got.overflow !== want.overflow ||
          got.build_done !== want.build_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                   results_seen, want.match_total, want.overflow, want.build_done,
                   got.match_total, got.overflow, got.build_done);
      end
    end
    results_seen++;
  endtask

  // receiver: random stalls, plus one long hold-off so the input backs up
  int hold_left = 0;
  int gap_left = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_result(out_data);
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [2:0] cmd;
    logic [4:0] letter;
  } row_t;

  // before the build every result is all zero
  row_t rows[] = '{
    '{mpmc_pkg::CMD_PAT_LETTER, 5'd0}, '{mpmc_pkg::CMD_PAT_LETTER, 5'd1},
    '{mpmc_pkg::CMD_PAT_END, 5'd0}, '{mpmc_pkg::CMD_PAT_LETTER, 5'd25},
    '{mpmc_pkg::CMD_PAT_LETTER, LETTER_MAX}, '{mpmc_pkg::CMD_PAT_END, 5'd21},
    '{mpmc_pkg::CMD_PAT_END, 5'd0}, '{mpmc_pkg::CMD_TEXT, 5'd0},
    '{mpmc_pkg::CMD_TEXT, LETTER_MAX}, '{mpmc_pkg::CMD_RESTART, 5'd10},
    '{mpmc_pkg::CMD_PAT_LETTER, 5'd2}, '{mpmc_pkg::CMD_RESTART, 5'd0},
    '{mpmc_pkg::CMD_PAT_LETTER, 5'd0}, '{mpmc_pkg::CMD_PAT_LETTER, 5'd0},
    '{mpmc_pkg::CMD_PAT_END, 5'd0}, '{CMD_UNUSED_LO, 5'd0},
    '{CMD_UNUSED_MID, LETTER_MAX}, '{CMD_UNUSED_HI, 5'd21},
    '{mpmc_pkg::CMD_PAT_LETTER, 5'd3}, '{mpmc_pkg::CMD_PAT_LETTER, 5'd26},
    '{mpmc_pkg::CMD_PAT_END, 5'd0}, '{mpmc_pkg::CMD_TEXT, 5'd3}
  };

  initial begin
    int len, k;
    logic [4:0] l;
    for (int i = 0; i < NODES*ALPHA; i++) trie_next[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      fail_of[i] = '0;
      ends_at[i] = '0;
      seen_node[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send(rows[i].cmd, rows[i].letter, 1'b1, '0);

    // short patterns over a few letters so the text finds matches
    for (int p = 0; p < 120; p++) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          k = $urandom_range(0, 3);
          if (k == 0) send(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), 5'($urandom));
          else if (k == 1) send(mpmc_pkg::CMD_PAT_LETTER, 5'($urandom_range(26, 31)));
          else if (k == 2) send(mpmc_pkg::CMD_TEXT, 5'($urandom));
          else send(mpmc_pkg::CMD_RESTART, 5'($urandom));
        end
        send(mpmc_pkg::CMD_PAT_LETTER, pick_letter());
      end
      send(mpmc_pkg::CMD_PAT_END, 5'($urandom));
    end

    drain();
    send(mpmc_pkg::CMD_BUILD, 5'($urandom));

    for (int i = 0; i < 800; i++) begin
      if (i == 500) drain();
      // a stretch with no idling on either side
      if (i == 600) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (i == 700) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      k = $urandom_range(0, 39);
      if (k == 0) send(mpmc_pkg::CMD_RESTART, 5'($urandom));
      else if (k == 1) send(mpmc_pkg::CMD_TEXT, 5'($urandom_range(26, 31)));
      else if (k == 2) send(mpmc_pkg::CMD_PAT_LETTER, 5'($urandom));
      else if (k == 3) send(mpmc_pkg::CMD_PAT_END, 5'($urandom));
      else if (k == 4) send(mpmc_pkg::CMD_BUILD, 5'($urandom));
      else if (k == 5) send(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), 5'($urandom));
      else begin
        l = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 25)) : 5'($urandom_range(0, 3));
        send(mpmc_pkg::CMD_TEXT, l);
      end
    end

    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk);
    $display("covered %0d pattern and %0d text transfers, %0d trie nodes, %0d overflows",
             pattern_sent, text_sent, used_nodes, ovf_hits);
    $display("checked %0d results, final match total %0d, %0d mismatches",
             results_seen, total_hits, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
